// ----- design/smre_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smre_pkg
// Shared types and constants for the source map run encoder.
// ----------------------------------------------------------------------------
package smre_pkg;

   localparam int DELTA_WIDTH = 13;
   localparam int MAX_RESULTS = 36;

   // request payload width, padded to whole bytes
   localparam int REQ_DATA_W = ((DELTA_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = 16;

   // remainder width: holds a move plus an open delta, and the clamp limit
   localparam int REM_W = (DELTA_WIDTH + 1 > 14) ? DELTA_WIDTH + 1 : 14;

   typedef logic signed [REM_W-1:0] rem_type;

   localparam rem_type REM_LIMIT    = rem_type'(127 * (MAX_RESULTS - 1));
   localparam rem_type REM_FILL_POS = rem_type'(127);
   localparam rem_type REM_FILL_NEG = rem_type'(-127);

   localparam logic signed [7:0] DELTA_RESET    = 8'sh80;
   localparam logic signed [7:0] DELTA_FILL_POS = 8'sd127;
   localparam logic signed [7:0] DELTA_FILL_NEG = -8'sd127;
   localparam logic [7:0]        LENGTH_FULL    = 8'd255;

   typedef enum logic [1:0] {
      OP_CODE_BYTE = 2'd0,
      OP_MOVE      = 2'd1,
      OP_FILE      = 2'd2,
      OP_FLUSH     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_FILL = 2'b10
   } state_type;

   typedef struct packed {
      logic              last;
      logic              final_entry;
      logic [7:0]        entry_length;
      logic signed [7:0] entry_delta;
   } entry_type;

endpackage

// ----- design/source_map_run_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_map_run_encoder
// Turns a stream of code-byte, move, file and flush transactions into
// (signed delta, length) map entries, holding one entry open at a time.
// ----------------------------------------------------------------------------
// a request's result is held in the output register from the cycle after it is taken
// throughput: one request per cycle unless stalled; a move needing filler entries
//   blocks requests until its fillers (up to 33) come from the shared +-127 adder loop
// a request is taken only while the output register is free or being drained
// reset: synchronous, returns to idle and clears the open entry and the output valid
module source_map_run_encoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [smre_pkg::REQ_DATA_W-1:0] req_tdata,  // delta
   input  logic [1:0]                      req_tuser,  // operation
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [smre_pkg::RSP_DATA_W-1:0] rsp_tdata,  // entry_delta, entry_length
   output logic                            rsp_tlast,  // last
   output logic                            rsp_tuser   // final_entry
);
   import smre_pkg::*;

   state_type         state_ff, state_in;
   logic              open_valid_ff, open_valid_in;
   logic signed [7:0] open_delta_ff, open_delta_in;
   logic [7:0]        open_length_ff, open_length_in;
   rem_type           rem_ff, rem_in;
   logic              rsp_valid_ff, rsp_valid_in;
   entry_type         rsp_ff, rsp_in;

   op_type                  op;
   logic signed [DELTA_WIDTH-1:0] req_delta;
   logic                    out_free;
   logic                    req_fire;
   logic                    merge;
   rem_type                 add_a, add_b, add_sum;
   rem_type                 pos;
   logic                    pos_big;
   logic                    sum_small;
   logic [7:0]              len_next;
   logic signed [7:0]       delta_base;

   assign op        = op_type'(req_tuser);
   assign req_delta = signed'(req_tdata[DELTA_WIDTH-1:0]);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req_tvalid && req_tready;

   // a zero-length, non-reset open entry folds into the next move
   assign merge = open_valid_ff && (open_length_ff == 8'd0) && (open_delta_ff != DELTA_RESET);

   // shared adder: combines move and a merged open delta on accept, steps fillers after
   always_comb begin
      if (state_ff == ST_IDLE) begin
         add_a = rem_type'(req_delta);
         add_b = merge ? rem_type'(open_delta_ff) : rem_type'(0);
      end else begin
         add_a = rem_ff;
         add_b = (rem_ff > 0) ? REM_FILL_NEG : REM_FILL_POS;
      end
      add_sum = add_a + add_b;
   end

   always_comb begin
      if (add_sum > REM_LIMIT) begin
         pos = REM_LIMIT;
      end else if (add_sum < -REM_LIMIT) begin
         pos = -REM_LIMIT;
      end else begin
         pos = add_sum;
      end
   end

   assign pos_big   = (pos > REM_FILL_POS) || (pos < REM_FILL_NEG);
   assign sum_small = (add_sum <= REM_FILL_POS) && (add_sum >= REM_FILL_NEG);

   assign delta_base = open_valid_ff ? open_delta_ff : 8'sd0;
   assign len_next   = (open_valid_ff ? open_length_ff : 8'd0) + 8'd1;

   always_comb begin
      state_in       = state_ff;
      open_valid_in  = open_valid_ff;
      open_delta_in  = open_delta_ff;
      open_length_in = open_length_ff;
      rem_in         = rem_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_in         = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (op)
                  OP_CODE_BYTE: begin
                     open_valid_in = 1'b1;
                     if (len_next == LENGTH_FULL) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{last: 1'b1, final_entry: 1'b0,
                                         entry_length: LENGTH_FULL,
                                         entry_delta: delta_base};
                        open_delta_in  = 8'sd0;
                        open_length_in = 8'd0;
                     end else begin
                        open_delta_in  = delta_base;
                        open_length_in = len_next;
                     end
                  end
                  OP_MOVE: begin
                     if (req_delta != '0) begin
                        if (open_valid_ff && !merge) begin
                           rsp_valid_in = 1'b1;
                           rsp_in       = '{last: !pos_big, final_entry: 1'b0,
                                            entry_length: open_length_ff,
                                            entry_delta: open_delta_ff};
                        end
                        if (pos_big) begin
                           rem_in   = pos;
                           state_in = ST_FILL;
                        end else begin
                           open_valid_in  = 1'b1;
                           open_delta_in  = pos[7:0];
                           open_length_in = 8'd0;
                        end
                     end
                  end
                  OP_FILE: begin
                     if (open_valid_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{last: 1'b1, final_entry: 1'b0,
                                         entry_length: open_length_ff,
                                         entry_delta: open_delta_ff};
                     end
                     open_valid_in  = 1'b1;
                     open_delta_in  = DELTA_RESET;
                     open_length_in = 8'd0;
                  end
                  OP_FLUSH: begin
                     if (open_valid_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{last: 1'b1, final_entry: 1'b1,
                                         entry_length: open_length_ff,
                                         entry_delta: open_delta_ff};
                     end
                     open_valid_in  = 1'b0;
                     open_delta_in  = 8'sd0;
                     open_length_in = 8'd0;
                  end
                  default: begin
                     open_valid_in = open_valid_ff;
                  end
               endcase
            end
         end
         ST_FILL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{last: sum_small, final_entry: 1'b0,
                                entry_length: 8'd0,
                                entry_delta: (rem_ff > 0) ? DELTA_FILL_POS : DELTA_FILL_NEG};
               rem_in = add_sum;
               if (sum_small) begin
                  open_valid_in  = 1'b1;
                  open_delta_in  = add_sum[7:0];
                  open_length_in = 8'd0;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         open_valid_ff  <= 1'b0;
         open_delta_ff  <= 8'sd0;
         open_length_ff <= 8'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         open_valid_ff  <= open_valid_in;
         open_delta_ff  <= open_delta_in;
         open_length_ff <= open_length_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.entry_length, rsp_ff.entry_delta};
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tuser  = rsp_ff.final_entry;

`ifndef NO_ASSERTIONS
   // filler loop only runs while the remainder is out of byte range
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> ((rem_ff > REM_FILL_POS) || (rem_ff < REM_FILL_NEG)))
      else $error("filler state with remainder in byte range");

   // a full-length entry is always emitted, never held open
   a_len_full: assert property (@(posedge clock) disable iff (reset)
      open_valid_ff |-> (open_length_ff != LENGTH_FULL))
      else $error("open entry reached full length");

   // flush closes the map
   a_flush_close: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (op == OP_FLUSH)) |=> !open_valid_ff)
      else $error("entry left open after flush");

   // a filler entry never covers code bytes nor closes the map
   a_fill_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && out_free) |=>
         (rsp_valid_ff && rsp_ff.entry_length == 8'd0 && !rsp_ff.final_entry))
      else $error("bad filler entry");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the source map run encoder. A queue of code-byte,
// move, file and flush transactions drives the request stream with random
// gaps. A behavioral encoder predicts the map entries, and every response is
// checked in order against them while the response side stalls at random.
// ----------------------------------------------------------------------------
module testbench;
   import smre_pkg::*;

   localparam int FILL_LIMIT = 127 * (MAX_RESULTS - 1);

   typedef struct packed {
      op_type                        operation;
      logic signed [DELTA_WIDTH-1:0] delta;
   } request_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = OP_CODE_BYTE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;

   request_type       requests_to_send[$];
   request_type       request_on_bus;
   entry_type         map_entries_due[$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                random_items;
   int                long_runs;
   int                pick;

   // predicted encoder state
   logic              open_valid = 1'b0;
   logic signed [7:0] open_delta = '0;
   logic [7:0]        open_length = '0;

   source_map_run_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // no idling on either side inside this window
   function automatic logic take_a_gap();
      if (cycle_count >= 300 && cycle_count < 1000) begin
         return 1'b0;
      end
      return $urandom_range(99) < 16;
   endfunction

   function automatic void push_entry(int entry_delta, logic [7:0] length, logic closing);
      entry_type e;
      e.entry_delta  = 8'(entry_delta);
      e.entry_length = length;
      e.last         = 1'b0;
      e.final_entry  = closing;
      map_entries_due.push_back(e);
   endfunction

   function automatic void encode_request(request_type req);
      int remaining;
      int due_before;
      due_before = map_entries_due.size();
      remaining  = int'(req.delta);
      case (req.operation)
         OP_CODE_BYTE: begin
            if (!open_valid) begin
               open_valid  = 1'b1;
               open_delta  = '0;
               open_length = '0;
            end
            open_length = open_length + 8'd1;
            if (open_length == LENGTH_FULL) begin
               push_entry(int'(open_delta), open_length, 1'b0);
               open_delta  = '0;
               open_length = '0;
            end
         end
         OP_MOVE: begin
            if (remaining != 0) begin
               if (open_valid) begin
                  // an empty non-reset entry absorbs the move instead of closing
                  if (open_length == 8'd0 && open_delta != DELTA_RESET) begin
                     remaining += int'(open_delta);
                  end else begin
                     push_entry(int'(open_delta), open_length, 1'b0);
                  end
               end
               if (remaining > FILL_LIMIT) remaining = FILL_LIMIT;
               if (remaining < -FILL_LIMIT) remaining = -FILL_LIMIT;
               while (remaining > 127) begin
                  push_entry(int'(DELTA_FILL_POS), 8'd0, 1'b0);
                  remaining -= 127;
               end
               while (remaining < -127) begin
                  push_entry(int'(DELTA_FILL_NEG), 8'd0, 1'b0);
                  remaining += 127;
               end
               open_valid  = 1'b1;
               open_delta  = 8'(remaining);
               open_length = '0;
            end
         end
         OP_FILE: begin
            if (open_valid) begin
               push_entry(int'(open_delta), open_length, 1'b0);
            end
            open_valid  = 1'b1;
            open_delta  = DELTA_RESET;
            open_length = '0;
         end
         default: begin
            if (open_valid) begin
               push_entry(int'(open_delta), open_length, 1'b1);
            end
            open_valid  = 1'b0;
            open_delta  = '0;
            open_length = '0;
         end
      endcase
      if (map_entries_due.size() > due_before) begin
         map_entries_due[map_entries_due.size() - 1].last = 1'b1;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            encode_request(request_on_bus);
         end
         if (!req_tvalid || req_tready) begin
            if (requests_to_send.size() != 0 && !take_a_gap()) begin
               request_on_bus = requests_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_DATA_W'(unsigned'(request_on_bus.delta));
               req_tuser  <= request_on_bus.operation;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (map_entries_due.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) begin
               $display("unexpected entry: delta %0d length %0d last %b final %b",
                        $signed(rsp_tdata[7:0]), rsp_tdata[15:8], rsp_tlast, rsp_tuser);
            end
         end else begin
            entry_type want;
            want = map_entries_due.pop_front();
            if (rsp_tdata[7:0] !== want.entry_delta || rsp_tdata[15:8] !== want.entry_length
                  || rsp_tlast !== want.last || rsp_tuser !== want.final_entry) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10) begin
                  $display("entry mismatch: expected delta %0d length %0d last %b final %b",
                           want.entry_delta, want.entry_length, want.last, want.final_entry);
                  $display("                got delta %0d length %0d last %b final %b",
                           $signed(rsp_tdata[7:0]), rsp_tdata[15:8], rsp_tlast, rsp_tuser);
               end
            end
         end
      end
      rsp_tready <= !take_a_gap();
   end

   task automatic send(op_type operation, int delta);
      request_type req;
      req.operation = operation;
      req.delta     = DELTA_WIDTH'(delta);
      requests_to_send.push_back(req);
   endtask

   // sender holds off until the encoder has nothing left to emit
   task automatic drain_all();
      while (requests_to_send.size() != 0 || req_tvalid || map_entries_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   function automatic int random_delta();
      int sel;
      sel = $urandom_range(9);
      if (sel < 5) return $urandom_range(400) - 200;
      if (sel < 8) return int'($signed(13'($urandom_range(8191))));
      if (sel == 8) return ($urandom_range(1) != 0) ? 4095 : -4096;
      return 0;
   endfunction

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty flush, zero move, merges, splits, reset entries
      send(OP_FLUSH, 0);
      send(OP_MOVE, 0);
      send(OP_CODE_BYTE, 4095);
      send(OP_CODE_BYTE, -4096);
      send(OP_MOVE, 4095);
      send(OP_MOVE, -4096);
      send(OP_CODE_BYTE, 0);
      send(OP_MOVE, 0);
      send(OP_MOVE, 1);
      send(OP_MOVE, -1);
      send(OP_MOVE, 127);
      send(OP_CODE_BYTE, 0);
      send(OP_MOVE, 128);
      send(OP_MOVE, -128);
      send(OP_CODE_BYTE, 0);
      send(OP_FILE, 0);
      send(OP_MOVE, 5);
      send(OP_FILE, 0);
      send(OP_CODE_BYTE, 0);
      send(OP_FILE, 0);
      send(OP_FLUSH, 0);
      send(OP_FLUSH, 0);
      send(OP_MOVE, -127);
      send(OP_MOVE, -127);
      send(OP_FLUSH, 0);
      drain_all();

      // a run long enough to split at full length
      for (int i = 0; i < 258; i++) send(OP_CODE_BYTE, random_delta());
      send(OP_FLUSH, 0);
      drain_all();

      random_items = 0;
      long_runs    = 0;
      while (random_items < 200) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            for (int i = $urandom_range(6, 1); i > 0; i--) begin
               send(OP_CODE_BYTE, random_delta());
               random_items++;
            end
         end else if (pick < 65) begin
            send(OP_MOVE, random_delta());
            random_items++;
         end else if (pick < 76) begin
            send(OP_MOVE, random_delta());
            send(OP_MOVE, random_delta());
            send(OP_CODE_BYTE, random_delta());
            random_items += 3;
         end else if (pick < 86) begin
            send(OP_FILE, random_delta());
            random_items++;
         end else if (pick < 94) begin
            send(OP_FLUSH, random_delta());
            random_items++;
         end else if (long_runs < 2) begin
            for (int i = $urandom_range(300, 250); i > 0; i--) begin
               send(OP_CODE_BYTE, random_delta());
               random_items++;
            end
            long_runs++;
         end
         if (random_items >= 100 && random_items < 104) begin
            drain_all();
         end
      end

      while (requests_to_send.size() != 0 || req_tvalid) begin
         @(negedge clock);
      end
      while (map_entries_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && map_entries_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// ----- source_map_run_encoder.f -----
design/smre_pkg.sv
design/source_map_run_encoder.sv
tb/testbench.sv
